// ===== rtl/core/rptm_pkg.sv =====
// ----------------------------------------------------------------------------
// rptm_pkg
// Shared types and constants of the ROI percentile threshold mask block.
// ----------------------------------------------------------------------------
package rptm_pkg;

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int ROI_W      = 14;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int CNT_W      = 25;
  localparam int NEED_W     = 32;
  localparam int ACC_W      = 33;
  localparam int SPAN_W     = 16;

  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [DIM_W-1:0] RST_IMAGE_DIM = 13'd4096;
  localparam logic [ROI_W-1:0] RST_ROI_FIRST = 14'd0;
  localparam logic [ROI_W-1:0] RST_ROI_LAST  = 14'd4095;
  localparam logic [PCT_W-1:0] RST_KEEP_PCT  = 7'd80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_ROI_FIRST_COL = 3'd2,
    CFG_ROI_LAST_COL  = 3'd3,
    CFG_ROI_FIRST_ROW = 3'd4,
    CFG_ROI_LAST_ROW  = 3'd5,
    CFG_KEEP_PERCENT  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ITEM_HIST      = 2'd0,
    ITEM_HIST_LAST = 2'd1,
    ITEM_MASK      = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e         kind;
    logic               roi_hit;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } qentry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_WAIT,
    ST_SCAN,
    ST_FLUSH,
    ST_REPORT
  } back_state_e;

endpackage

// ===== rtl/core/rptm_in_if.sv =====
// ----------------------------------------------------------------------------
// rptm_in_if
// Pixel request channel: valid, ready and one pixel with its position.
// ----------------------------------------------------------------------------
interface rptm_in_if #(
  parameter int VALUE_BITS = 12
) ();
  import rptm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [VALUE_BITS-1:0] pixel_value;
  logic [COORD_W-1:0]           column;
  logic [COORD_W-1:0]           row;
  logic                         frame_last;

  modport source (output valid, func, pixel_value, column, row, frame_last, input ready);
  modport sink   (input valid, func, pixel_value, column, row, frame_last, output ready);
endinterface

// ===== rtl/core/rptm_out_if.sv =====
// ----------------------------------------------------------------------------
// rptm_out_if
// Result request channel: threshold reports and mask pixels.
// ----------------------------------------------------------------------------
interface rptm_out_if #(
  parameter int VALUE_BITS = 12
) ();
  import rptm_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic                         marked;
  logic signed [VALUE_BITS-1:0] threshold_value;
  logic [COORD_W-1:0]           out_column;
  logic [COORD_W-1:0]           out_row;

  modport source (output valid, result_kind, marked, threshold_value, out_column, out_row,
                  input ready);
  modport sink   (input valid, result_kind, marked, threshold_value, out_column, out_row,
                  output ready);
endinterface

// ===== rtl/core/rptm_front.sv =====
// ----------------------------------------------------------------------------
// rptm_front
// Configuration registers, region clamp and request classification.
// ----------------------------------------------------------------------------
module rptm_front #(
  parameter int VALUE_BITS = 12,
  parameter int MAX_DIM    = 4096,
  parameter int QW         = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rptm_in_if.sink                         in_ch,
  input  logic                            cfg_we_i,
  input  logic [rptm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rptm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            block_i,
  input  logic                            push_ready_i,
  output logic                            push_o,
  output logic [QW-1:0]                   push_data_o,
  output logic [rptm_pkg::PCT_W-1:0]      keep_pct_o
);
  import rptm_pkg::*;

  typedef struct packed {
    logic signed [SPAN_W-1:0] lo;
    logic signed [SPAN_W-1:0] hi;
  } span_t;

  localparam logic signed [SPAN_W-1:0] DimCap = SPAN_W'(MAX_DIM);

  logic [DIM_W-1:0] width_q, height_q;
  logic [ROI_W-1:0] fcol_q, lcol_q, frow_q, lrow_q;
  logic [PCT_W-1:0] keep_q;

  span_t   col_span, row_span;
  logic    roi_hit;
  qentry_t entry;
  logic signed [SPAN_W-1:0] col_s, row_s;

  function automatic span_t clamp_span(logic [DIM_W-1:0] dim, logic [ROI_W-1:0] first,
                                       logic [ROI_W-1:0] last);
    logic signed [SPAN_W-1:0] lim, a, b, dim_s;
    span_t s;
    dim_s = $signed({{(SPAN_W-DIM_W){1'b0}}, dim});
    lim = (dim_s > DimCap) ? DimCap - 16'sd1 : dim_s - 16'sd1;
    a = $signed({{(SPAN_W-ROI_W){first[ROI_W-1]}}, first});
    b = $signed({{(SPAN_W-ROI_W){last[ROI_W-1]}}, last});
    if (a < 0) a = '0;
    if (a > lim) a = lim;
    if (b < 0) b = '0;
    if (b > lim) b = lim;
    if (b < a) b = a;
    s.lo = a;
    s.hi = b;
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_DIM;
      height_q <= RST_IMAGE_DIM;
      fcol_q   <= RST_ROI_FIRST;
      lcol_q   <= RST_ROI_LAST;
      frow_q   <= RST_ROI_FIRST;
      lrow_q   <= RST_ROI_LAST;
      keep_q   <= RST_KEEP_PCT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[DIM_W-1:0];
        CFG_ROI_FIRST_COL: fcol_q   <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_LAST_COL:  lcol_q   <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_FIRST_ROW: frow_q   <= cfg_data_i[ROI_W-1:0];
        CFG_ROI_LAST_ROW:  lrow_q   <= cfg_data_i[ROI_W-1:0];
        CFG_KEEP_PERCENT:  keep_q   <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_span = clamp_span(width_q, fcol_q, lcol_q);
    row_span = clamp_span(height_q, frow_q, lrow_q);
    col_s    = $signed({{(SPAN_W-COORD_W){1'b0}}, in_ch.column});
    row_s    = $signed({{(SPAN_W-COORD_W){1'b0}}, in_ch.row});
    roi_hit  = (col_s >= col_span.lo) && (col_s <= col_span.hi) &&
               (row_s >= row_span.lo) && (row_s <= row_span.hi);
    entry.kind    = in_ch.func ? ITEM_MASK : (in_ch.frame_last ? ITEM_HIST_LAST : ITEM_HIST);
    entry.roi_hit = roi_hit;
    entry.col     = in_ch.column;
    entry.row     = in_ch.row;
  end

  assign in_ch.ready = push_ready_i && !block_i;
  assign push_o      = in_ch.valid && in_ch.ready;
  assign push_data_o = {entry, in_ch.pixel_value};
  assign keep_pct_o  = (keep_q > PCT_FULL) ? PCT_FULL : keep_q;

endmodule

// ===== rtl/core/rptm_queue.sv =====
// ----------------------------------------------------------------------------
// rptm_queue
// Short FIFO between the classifying front and the histogram back end.
// ----------------------------------------------------------------------------
module rptm_queue #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i) rd_q <= bump(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

  assign not_full_o = (cnt_q != CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_q];

endmodule

// ===== rtl/core/rptm_back.sv =====
// ----------------------------------------------------------------------------
// rptm_back
// Histogram memory, percentile scan and result register.
// ----------------------------------------------------------------------------
module rptm_back #(
  parameter int VALUE_BITS = 12,
  parameter int QW         = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  logic [QW-1:0]              pop_data_i,
  output logic                       pop_o,
  input  logic [rptm_pkg::PCT_W-1:0] keep_pct_i,
  output logic                       clearing_o,
  rptm_out_if.source                 out_ch
);
  import rptm_pkg::*;

  localparam int NBins = 1 << VALUE_BITS;
  localparam logic [VALUE_BITS-1:0] AddrTop    = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] AddrBottom = {1'b1, {(VALUE_BITS-1){1'b0}}};

  back_state_e state_q, state_d;

  logic [CNT_W-1:0] hist_mem [NBins];
  logic [CNT_W-1:0] rdata_q;
  logic [VALUE_BITS-1:0] mem_raddr, mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic mem_we;

  qentry_t entry;
  logic [VALUE_BITS-1:0] value;

  logic [VALUE_BITS-1:0] addr_q;
  logic [CNT_W-1:0] total_q;
  logic [VALUE_BITS-1:0] thr_q;
  logic [NEED_W-1:0] need_q;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic found_q;

  logic p1_v_q;
  logic [VALUE_BITS-1:0] p1_addr_q;
  logic [CNT_W-1:0] p1_data;
  logic fwd_v_q;
  logic [VALUE_BITS-1:0] fwd_addr_q;
  logic [CNT_W-1:0] fwd_data_q;

  logic s1_v_q, s2_v_q, s2_nz_q;
  logic [VALUE_BITS-1:0] s1_val_q, s2_val_q;
  logic [NEED_W-1:0] s2_n100_q;

  logic out_v_q, out_kind_q, out_marked_q;
  logic [VALUE_BITS-1:0] out_thr_q;
  logic [COORD_W-1:0] out_col_q, out_row_q;

  logic out_load, sweep, hist_pop, load_mask, load_thr, hit;
  logic [PCT_W-1:0] keep_rest;

  assign entry = pop_data_i[QW-1:VALUE_BITS];
  assign value = pop_data_i[VALUE_BITS-1:0];
  assign out_load = !out_v_q || out_ch.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (addr_q == AddrBottom) state_d = ST_RUN;
      ST_RUN:    if (!empty_i && entry.kind == ITEM_HIST_LAST) state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_SCAN;
      ST_SCAN:   if (addr_q == AddrBottom) state_d = ST_FLUSH;
      ST_FLUSH:  if (!s1_v_q && !s2_v_q) state_d = ST_REPORT;
      ST_REPORT: if (out_load) state_d = ST_RUN;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sweep      = (state_q == ST_CLEAR) || (state_q == ST_SCAN);
    clearing_o = (state_q == ST_CLEAR);
    pop_o      = (state_q == ST_RUN) && !empty_i && (entry.kind != ITEM_MASK || out_load);
    hist_pop   = pop_o && (entry.kind != ITEM_MASK) && entry.roi_hit;
    load_mask  = pop_o && (entry.kind == ITEM_MASK);
    load_thr   = (state_q == ST_REPORT) && out_load;
  end

  always_comb begin
    p1_data   = (fwd_v_q && fwd_addr_q == p1_addr_q) ? fwd_data_q : rdata_q;
    mem_raddr = sweep ? addr_q : value;
    mem_we    = sweep || p1_v_q;
    mem_waddr = sweep ? addr_q : p1_addr_q;
    mem_wdata = sweep ? '0 : ((p1_data == CNT_MAX) ? p1_data : p1_data + 1'b1);
    keep_rest = PCT_FULL - keep_pct_i;
    acc_d     = acc_q + ACC_W'(s2_n100_q);
    hit       = s2_v_q && !found_q && s2_nz_q && (acc_d >= ACC_W'(need_q));
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= hist_mem[mem_raddr];
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= AddrTop;
      total_q <= '0;
      thr_q   <= '0;
      found_q <= 1'b0;
      p1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sweep) addr_q <= addr_q - 1'b1;
      if (state_q == ST_WAIT) total_q <= '0;
      else if (hist_pop && total_q != CNT_MAX) total_q <= total_q + 1'b1;
      if (state_q == ST_WAIT) found_q <= 1'b0;
      else if (hit) found_q <= 1'b1;
      if (hit) thr_q <= s2_val_q;
      p1_v_q  <= hist_pop;
      fwd_v_q <= mem_we;
      s1_v_q  <= (state_q == ST_SCAN);
      s2_v_q  <= s1_v_q;
      if (load_mask || load_thr) out_v_q <= 1'b1;
      else if (out_ch.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_addr_q  <= value;
    fwd_addr_q <= mem_waddr;
    fwd_data_q <= mem_wdata;
    s1_val_q   <= addr_q;
    s2_val_q   <= s1_val_q;
    s2_nz_q    <= (rdata_q != '0);
    s2_n100_q  <= NEED_W'(rdata_q) * NEED_W'(PCT_FULL);
    if (state_q == ST_WAIT) begin
      need_q <= NEED_W'(keep_rest) * NEED_W'(total_q);
      acc_q  <= '0;
    end else if (s2_v_q && !found_q && s2_nz_q) begin
      acc_q <= acc_d;
    end
    if (load_mask) begin
      out_kind_q   <= 1'b1;
      out_marked_q <= entry.roi_hit && ($signed(value) >= $signed(thr_q));
      out_thr_q    <= thr_q;
      out_col_q    <= entry.col;
      out_row_q    <= entry.row;
    end else if (load_thr) begin
      out_kind_q   <= 1'b0;
      out_marked_q <= 1'b0;
      out_thr_q    <= thr_q;
      out_col_q    <= '0;
      out_row_q    <= '0;
    end
  end

  assign out_ch.valid           = out_v_q;
  assign out_ch.result_kind     = out_kind_q;
  assign out_ch.marked          = out_marked_q;
  assign out_ch.threshold_value = out_thr_q;
  assign out_ch.out_column      = out_col_q;
  assign out_ch.out_row         = out_row_q;

endmodule

// ===== rtl/core/roi_percentile_threshold_mask_top.sv =====
// ----------------------------------------------------------------------------
// roi_percentile_threshold_mask_top
// Percentile threshold over a region of interest, then a per-pixel mask.
// ----------------------------------------------------------------------------
// A mask request passes through the queue and the output register, one pixel per cycle
// while nothing stalls the queue or the output. Histogram pixels give no result.
// The frame-last pixel starts a sweep of the bin memory (one read and one write port);
// the threshold result follows the scan, flush and report states; input stalls once the queue fills.
// Reset: the bin memory is then cleared, with input ready held low meanwhile.
module roi_percentile_threshold_mask_top #(
  parameter int VALUE_BITS = 12,
  parameter int MAX_DIM    = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rptm_in_if.sink                         in_ch,
  rptm_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [rptm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rptm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rptm_pkg::*;

  localparam int QW         = $bits(qentry_t) + VALUE_BITS;
  localparam int QueueDepth = 4;

  logic          push, push_ready, pop, empty, clearing;
  logic [QW-1:0] push_data, pop_data;
  logic [PCT_W-1:0] keep_pct;

  rptm_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIM   (MAX_DIM),
    .QW        (QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .block_i     (clearing),
    .push_ready_i(push_ready),
    .push_o      (push),
    .push_data_o (push_data),
    .keep_pct_o  (keep_pct)
  );

  rptm_queue #(
    .WIDTH(QW),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .not_full_o (push_ready),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  rptm_back #(
    .VALUE_BITS(VALUE_BITS),
    .QW        (QW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .pop_data_i(pop_data),
    .pop_o     (pop),
    .keep_pct_i(keep_pct),
    .clearing_o(clearing),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/core/rptm_checker.sv =====
// ----------------------------------------------------------------------------
// rptm_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rptm_checker #(
  parameter int VALUE_BITS = 12
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic                                result_kind_i,
  input logic                                marked_i,
  input logic [VALUE_BITS-1:0]               threshold_value_i,
  input logic [rptm_pkg::COORD_W-1:0]        out_column_i,
  input logic [rptm_pkg::COORD_W-1:0]        out_row_i
);
  import rptm_pkg::*;

  logic [1+1+VALUE_BITS+2*COORD_W-1:0] payload;
  assign payload = {result_kind_i, marked_i, threshold_value_i, out_column_i, out_row_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload))
    else $error("result request changed while stalled");

  a_thr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !result_kind_i |-> !marked_i && out_column_i == '0 && out_row_i == '0)
    else $error("threshold result carries mask fields");

  a_thr_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && result_kind_i) ##1 (out_valid_i && result_kind_i)
      |-> threshold_value_i == $past(threshold_value_i))
    else $error("threshold moved between back-to-back mask results");

endmodule

bind roi_percentile_threshold_mask_top rptm_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_rptm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .result_kind_i    (out_ch.result_kind),
  .marked_i         (out_ch.marked),
  .threshold_value_i(out_ch.threshold_value),
  .out_column_i     (out_ch.out_column),
  .out_row_i        (out_ch.out_row)
);
